@@ sv/etuc_pkg.sv @@
// ----------------------------------------------------------------------------
// etuc_pkg
// Shared constants and the cumulative-days table for the epoch to UTC
// calendar converter.
// ----------------------------------------------------------------------------
package etuc_pkg;

  localparam int SECONDS_WIDTH_DEF = 40;

  localparam int SEC_PER_DAY   = 86400;
  localparam int DAYS_PER_ERA  = 146097;   // 400 Gregorian years
  localparam int EPOCH_SHIFT   = 719468;   // days from 0000-03-01 to 1970-01-01
  localparam int DAY_RW        = 17;       // bits of a second-of-day
  localparam int ERA_RW        = 18;       // bits of a day-of-era

  // Reciprocals for the small constant divisions, floor(2^S / D).
  localparam int M1460 = 179;              // S = 18
  localparam int M365  = 718;              // S = 18
  localparam int M7    = 37449;            // S = 18
  localparam int M3600 = 36;               // S = 17
  localparam int M60   = 68;               // S = 12

  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      default: d = leap ? 9'd366 : 9'd365;
    endcase
    return d;
  endfunction

endpackage

@@ sv/etuc_fdiv.sv @@
// ----------------------------------------------------------------------------
// etuc_fdiv
// Pipelined floor division of a signed value by a constant, using a
// reciprocal multiplication, a one-step correction and a final stage that
// removes the sign bias. Four register stages.
// ----------------------------------------------------------------------------
module etuc_fdiv import etuc_pkg::*; #(
  parameter int W       = SECONDS_WIDTH_DEF,
  parameter int DIVISOR = SEC_PER_DAY,
  parameter int RW      = DAY_RW,
  parameter int SIDE_W  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_num,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [W-1:0] out_quo,
  output logic [RW-1:0]       out_rem,
  output logic [SIDE_W-1:0]   out_side
);

  // The signed input is biased by 2^(W-1); the bias is divided out here.
  localparam logic [W-1:0]  BIAS = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  QB   = BIAS / W'(DIVISOR);
  localparam logic [W-1:0]  RBW  = BIAS % W'(DIVISOR);
  localparam logic [RW:0]   RB   = RBW[RW:0];
  localparam logic [RW:0]   DV   = (RW+1)'(DIVISOR);

  // The reciprocal floor(2^W / DIVISOR) gives a quotient that is low by at
  // most one, so a single compare and subtract finishes the job.
  localparam int            H     = W / 2;
  localparam int            MW    = W - $clog2(DIVISOR) + 1;
  localparam logic [W:0]    TWO_W = {1'b1, {W{1'b0}}};
  localparam logic [MW-1:0] MR    = MW'(TWO_W / (W+1)'(DIVISOR));

  logic              va_r, vb_r, vc_r;
  logic [W-1:0]      ua_r;
  logic [H+MW-1:0]   plo_a_r;
  logic [MW-1:0]     qb_r;
  logic [RW:0]       ulo_b_r;
  logic [W-1:0]      qc_r;
  logic [RW-1:0]     rc_r;
  logic [SIDE_W-1:0] side_a_r, side_b_r, side_c_r;

  logic [W-1:0]      u;
  logic [W-H+MW-1:0] phi;
  logic [W+MW-1:0]   prod;
  logic [RW:0]       qd;
  logic [RW:0]       r_est;
  logic              ge;
  logic              lt;
  logic [RW:0]       rem_x;

  // Stage a: bias the input and form the low half product.
  always_comb begin
    u = {~in_num[W-1], in_num[W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
    if (adv) begin
      ua_r     <= u;
      plo_a_r  <= (H+MW)'(u[H-1:0]) * (H+MW)'(MR);
      side_a_r <= in_side;
    end
  end

  // Stage b: add the high half product and take the quotient estimate.
  always_comb begin
    phi  = (W-H+MW)'(ua_r[W-1:H]) * (W-H+MW)'(MR);
    prod = (W+MW)'(plo_a_r) + {phi, {H{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
    if (adv) begin
      qb_r     <= prod[W+MW-1:W];
      ulo_b_r  <= ua_r[RW:0];
      side_b_r <= side_a_r;
    end
  end

  // Stage c: the remainder is below twice the divisor, so only its low bits
  // are needed.
  always_comb begin
    qd    = (RW+1)'(qb_r) * DV;
    r_est = ulo_b_r - qd;
    ge    = (r_est >= DV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
    if (adv) begin
      qc_r     <= W'(qb_r) + W'(ge);
      rc_r     <= ge ? RW'(r_est - DV) : r_est[RW-1:0];
      side_c_r <= side_b_r;
    end
  end

  // Stage d: remove the bias and floor toward minus infinity.
  always_comb begin
    rem_x = {1'b0, rc_r};
    lt    = (rem_x < RB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vc_r;
    end
    if (adv) begin
      out_quo  <= $signed(qc_r - QB - W'(lt));
      out_rem  <= lt ? RW'(rem_x + DV - RB) : RW'(rem_x - RB);
      out_side <= side_c_r;
    end
  end

endmodule

@@ sv/etuc_cal.sv @@
// ----------------------------------------------------------------------------
// etuc_cal
// Turns a 400-year era, the day within it and the second of the day into
// the calendar and clock fields, over seven register stages.
// ----------------------------------------------------------------------------
module etuc_cal import etuc_pkg::*; #(
  parameter int W = SECONDS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_era,
  input  logic [ERA_RW-1:0]   in_doe,
  input  logic [DAY_RW-1:0]   in_rem,
  output logic                out_valid,
  output logic signed [15:0]  out_year_since_1900,
  output logic [3:0]          out_month_index,
  output logic [4:0]          out_day_of_month,
  output logic [4:0]          out_hour_of_day,
  output logic [5:0]          out_minute_of_hour,
  output logic [5:0]          out_second_of_minute,
  output logic [2:0]          out_weekday,
  output logic [8:0]          out_day_of_year
);

  localparam logic signed [W-1:0] YEAR_MIN = W'(-32768);
  localparam logic signed [W-1:0] YEAR_MAX = W'(32767);

  logic [5:0] v_r;

  // Stage 1: reciprocal products.
  logic signed [W-1:0] era1_r;
  logic [17:0]         doe1_r;
  logic [16:0]         rem1_r;
  logic [25:0]         p1460_r;
  logic [2:0]          c36k_r;
  logic                cend_r;
  logic [22:0]         ph_r;
  logic [33:0]         pw_r;

  // Stage 2.
  logic signed [W-1:0] era2_r;
  logic [17:0]         doe2_r, n2_r;
  logic [4:0]          hour2_r;
  logic [11:0]         r3600_2_r;
  logic [2:0]          wd2_r;

  // Stage 3.
  logic signed [W-1:0] era3_r;
  logic [17:0]         doe3_r, n3_r;
  logic [27:0]         pn_r;
  logic [18:0]         pm_r;
  logic [4:0]          hour3_r;
  logic [11:0]         r3600_3_r;
  logic [2:0]          wd3_r;

  // Stage 4.
  logic signed [W-1:0] era4_r;
  logic [17:0]         doe4_r;
  logic [8:0]          yoe4_r;
  logic [4:0]          hour4_r;
  logic [5:0]          min4_r, sec4_r;
  logic [2:0]          wd4_r;

  // Stage 5.
  logic signed [W-1:0] base5_r;
  logic [8:0]          doy5_r;
  logic                leap5_r, leap1_5_r;
  logic [4:0]          hour5_r;
  logic [5:0]          min5_r, sec5_r;
  logic [2:0]          wd5_r;

  // Stage 6.
  logic signed [15:0]  year6_r;
  logic [8:0]          doyj6_r;
  logic                leapc6_r;
  logic [4:0]          hour6_r;
  logic [5:0]          min6_r, sec6_r;
  logic [2:0]          wd6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_r       <= {v_r[4:0], in_valid};
      out_valid <= v_r[5];
    end
  end

  // Stage 1 ------------------------------------------------------------------
  logic [17:0] wx;
  always_comb begin
    wx = in_doe + 18'd3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      era1_r  <= in_era;
      doe1_r  <= in_doe;
      rem1_r  <= in_rem;
      p1460_r <= 26'(in_doe) * 26'(M1460);
      c36k_r  <= 3'(in_doe >= 18'd36524) + 3'(in_doe >= 18'd73048)
               + 3'(in_doe >= 18'd109572) + 3'(in_doe >= 18'd146096);
      cend_r  <= (in_doe == 18'd146096);
      ph_r    <= 23'(in_rem) * 23'(M3600);
      pw_r    <= 34'(wx) * 34'(M7);
    end
  end

  // Stage 2 ------------------------------------------------------------------
  logic [7:0]  q1460;
  logic [17:0] r1460;
  logic [7:0]  q1460c;
  logic [5:0]  h_est;
  logic [16:0] h_rem;
  logic [15:0] w_est;
  logic [17:0] w_rem;
  logic [17:0] w_x;

  always_comb begin
    q1460  = p1460_r[25:18];
    r1460  = doe1_r - 18'(q1460) * 18'd1460;
    q1460c = (r1460 >= 18'd1460) ? q1460 + 8'd1 : q1460;
    h_est  = ph_r[22:17];
    h_rem  = rem1_r - 17'(h_est) * 17'd3600;
    w_x    = doe1_r + 18'd3;
    w_est  = pw_r[33:18];
    w_rem  = w_x - 18'(w_est) * 18'd7;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      era2_r    <= era1_r;
      doe2_r    <= doe1_r;
      n2_r      <= doe1_r - 18'(q1460c) + 18'(c36k_r) - 18'(cend_r);
      hour2_r   <= (h_rem >= 17'd3600) ? 5'(h_est + 6'd1) : h_est[4:0];
      r3600_2_r <= (h_rem >= 17'd3600) ? 12'(h_rem - 17'd3600) : h_rem[11:0];
      wd2_r     <= (w_rem >= 18'd7) ? 3'(w_rem - 18'd7) : w_rem[2:0];
    end
  end

  // Stage 3 ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      era3_r    <= era2_r;
      doe3_r    <= doe2_r;
      n3_r      <= n2_r;
      pn_r      <= 28'(n2_r) * 28'(M365);
      pm_r      <= 19'(r3600_2_r) * 19'(M60);
      hour3_r   <= hour2_r;
      r3600_3_r <= r3600_2_r;
      wd3_r     <= wd2_r;
    end
  end

  // Stage 4 ------------------------------------------------------------------
  logic [8:0]  y_est;
  logic [17:0] y_rem;
  logic [5:0]  m_est;
  logic [11:0] m_rem;

  always_comb begin
    y_est = pn_r[26:18];
    y_rem = n3_r - 18'(y_est) * 18'd365;
    m_est = pm_r[17:12];
    m_rem = r3600_3_r - 12'(m_est) * 12'd60;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      era4_r  <= era3_r;
      doe4_r  <= doe3_r;
      yoe4_r  <= (y_rem >= 18'd365) ? y_est + 9'd1 : y_est;
      hour4_r <= hour3_r;
      min4_r  <= (m_rem >= 12'd60) ? m_est + 6'd1 : m_est;
      sec4_r  <= (m_rem >= 12'd60) ? 6'(m_rem - 12'd60) : m_rem[5:0];
      wd4_r   <= wd3_r;
    end
  end

  // Stage 5 ------------------------------------------------------------------
  // Years of the era start on March 1, so the leap day closes the year.
  logic [1:0]  c100;
  logic [2:0]  c100b;
  logic [8:0]  y1;
  logic [17:0] doy_full;
  logic        leap_y, leap_y1;

  always_comb begin
    c100     = 2'(yoe4_r >= 9'd100) + 2'(yoe4_r >= 9'd200) + 2'(yoe4_r >= 9'd300);
    y1       = yoe4_r + 9'd1;
    c100b    = 3'(y1 >= 9'd100) + 3'(y1 >= 9'd200) + 3'(y1 >= 9'd300)
             + 3'(y1 >= 9'd400);
    doy_full = doe4_r - 18'(yoe4_r) * 18'd365 - 18'(yoe4_r[8:2]) + 18'(c100);
    leap_y   = (yoe4_r[1:0] == 2'd0)
             && ((yoe4_r != 9'(c100) * 9'd100) || (yoe4_r == 9'd0));
    leap_y1  = (y1[1:0] == 2'd0)
             && ((y1 != 9'(c100b) * 9'd100) || (y1 == 9'd400));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base5_r   <= (era4_r <<< 8) + (era4_r <<< 7) + (era4_r <<< 4)
                 + $signed(W'(yoe4_r));
      doy5_r    <= doy_full[8:0];
      leap5_r   <= leap_y;
      leap1_5_r <= leap_y1;
      hour5_r   <= hour4_r;
      min5_r    <= min4_r;
      sec5_r    <= sec4_r;
      wd5_r     <= wd4_r;
    end
  end

  // Stage 6 ------------------------------------------------------------------
  logic                jan_feb;
  logic signed [W-1:0] yfull;

  always_comb begin
    jan_feb = (doy5_r >= 9'd306);
    yfull   = base5_r + $signed(W'(jan_feb)) - $signed(W'(1900));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (yfull < YEAR_MIN) begin
        year6_r <= -16'sd32768;
      end else if (yfull > YEAR_MAX) begin
        year6_r <= 16'sd32767;
      end else begin
        year6_r <= yfull[15:0];
      end
      doyj6_r  <= jan_feb ? doy5_r - 9'd306 : doy5_r + 9'd59 + 9'(leap5_r);
      leapc6_r <= jan_feb ? leap1_5_r : leap5_r;
      hour6_r  <= hour5_r;
      min6_r   <= min5_r;
      sec6_r   <= sec5_r;
      wd6_r    <= wd5_r;
    end
  end

  // Stage 7 ------------------------------------------------------------------
  logic [3:0] mon;
  logic [8:0] mstart;

  always_comb begin
    mon = '0;
    for (int k = 1; k < 12; k++) begin
      mon = mon + 4'(doyj6_r >= cum_days(leapc6_r, 4'(k)));
    end
    mstart = cum_days(leapc6_r, mon);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_year_since_1900  <= year6_r;
      out_month_index      <= mon;
      out_day_of_month     <= 5'(doyj6_r - mstart + 9'd1);
      out_hour_of_day      <= hour6_r;
      out_minute_of_hour   <= min6_r;
      out_second_of_minute <= sec6_r;
      out_weekday          <= wd6_r;
      out_day_of_year      <= doyj6_r;
    end
  end

endmodule

@@ sv/epoch_seconds_to_utc_calendar_top.sv @@
// Throughput: one beat per cycle while the output is not stalled; two
// four-stage reciprocal dividers (seconds per day, days per 400-year era) and
// the seven-stage calendar set the depth, which is the same at any SECONDS_WIDTH.
// The whole pipeline advances together and holds while a result waits.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_top
// Converts signed seconds since the Unix epoch to the UTC calendar fields.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_top import etuc_pkg::*; #(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SECONDS_WIDTH-1:0] in_epoch_seconds,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_year_since_1900,
  output logic [3:0]                      out_month_index,
  output logic [4:0]                      out_day_of_month,
  output logic [4:0]                      out_hour_of_day,
  output logic [5:0]                      out_minute_of_hour,
  output logic [5:0]                      out_second_of_minute,
  output logic [2:0]                      out_weekday,
  output logic [8:0]                      out_day_of_year
);

  localparam int W = SECONDS_WIDTH;

  logic                adv;
  logic                d_valid;
  logic signed [W-1:0] days;
  logic [DAY_RW-1:0]   sod;
  logic                e_valid;
  logic signed [W-1:0] era;
  logic [ERA_RW-1:0]   doe;
  logic [DAY_RW-1:0]   sod_e;
  logic signed [W-1:0] z;

  always_comb begin
    adv      = !out_valid || out_ready;
    in_ready = adv;
    z        = days + $signed(W'(EPOCH_SHIFT));
  end

  etuc_fdiv #(
    .W(W), .DIVISOR(SEC_PER_DAY), .RW(DAY_RW), .SIDE_W(1)
  ) u_day_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(in_valid), .in_num(in_epoch_seconds), .in_side(1'b0),
    .out_valid(d_valid), .out_quo(days), .out_rem(sod), .out_side()
  );

  etuc_fdiv #(
    .W(W), .DIVISOR(DAYS_PER_ERA), .RW(ERA_RW), .SIDE_W(DAY_RW)
  ) u_era_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(d_valid), .in_num(z), .in_side(sod),
    .out_valid(e_valid), .out_quo(era), .out_rem(doe), .out_side(sod_e)
  );

  etuc_cal #(.W(W)) u_cal (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(e_valid), .in_era(era), .in_doe(doe), .in_rem(sod_e),
    .out_valid(out_valid),
    .out_year_since_1900(out_year_since_1900),
    .out_month_index(out_month_index),
    .out_day_of_month(out_day_of_month),
    .out_hour_of_day(out_hour_of_day),
    .out_minute_of_hour(out_minute_of_hour),
    .out_second_of_minute(out_second_of_minute),
    .out_weekday(out_weekday),
    .out_day_of_year(out_day_of_year)
  );

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_of_day < 5'd24) && (out_minute_of_hour < 6'd60)
                  && (out_second_of_minute < 6'd60))
    else $error("clock fields out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index < 4'd12) && (out_day_of_month != 5'd0)
                  && (out_day_of_year < 9'd366))
    else $error("date fields out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday < 3'd7))
    else $error("weekday out of range");

  a_day_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid |-> (sod < DAY_RW'(SEC_PER_DAY)))
    else $error("second of day out of range");

endmodule
